@@ sv/swmr_pkg.sv @@
// shared types and constants of the sliding window max range unit
package swmr_pkg;

  // window and sample sizing
  localparam int WINDOW_MAX  = 1024;
  localparam int SAMPLE_BITS = 31;
  localparam int SLOT_BITS   = $clog2(WINDOW_MAX);
  localparam int LEN_BITS    = SLOT_BITS + 1;
  localparam int CFG_BITS    = 11;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SLOT_BITS-1:0]   slot_t;
  typedef logic [LEN_BITS-1:0]    len_t;
  typedef logic [CFG_BITS-1:0]    cfg_t;

  // one candidate queue entry: store slot and sample value
  typedef struct packed {
    slot_t   slot;
    sample_t val;
  } entry_t;

  // status a queue unit reports to the top level
  typedef struct packed {
    logic    done;
    sample_t front;
  } qstat_t;

  // clamp a configured length into 1 .. WINDOW_MAX
  function automatic len_t clamp_len(input cfg_t v);
    len_t r;
    if (v == '0) begin
      r = len_t'(1);
    end else if (CFG_BITS'(v) > CFG_BITS'(WINDOW_MAX)) begin
      r = len_t'(WINDOW_MAX);
    end else begin
      r = len_t'(v);
    end
    return r;
  endfunction

endpackage

@@ sv/swmr_ram.sv @@
// generic synchronous ram, one write port and two registered read ports
module swmr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 41
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic                     re_b_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, registered outputs
  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_o <= mem[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

@@ sv/swmr_queue.sv @@
// one monotonic candidate queue held in ram, with cached front and tail
module swmr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             max_mode_i,
  input  logic             start_i,
  input  logic             clear_i,
  input  swmr_pkg::sample_t sample_i,
  input  swmr_pkg::slot_t   slot_i,
  input  swmr_pkg::len_t    len_i,
  output swmr_pkg::qstat_t  stat_o
);
  import swmr_pkg::*;

  localparam logic [1:0] Q_IDLE = 2'd0;
  localparam logic [1:0] Q_BACK = 2'd1;
  localparam logic [1:0] Q_TAIL = 2'd2;

  logic [1:0] state_q, state_d;
  slot_t      head_q, head_d;
  len_t       cnt_q, cnt_d;
  logic       pend_q, pend_d;
  logic       done_q, done_d;
  slot_t      fslot_q, fslot_d;
  sample_t    fval_q, fval_d;
  sample_t    tval_q, tval_d;
  sample_t    x_q, x_d;
  slot_t      s_q, s_d;

  logic   we, re_a, re_b;
  slot_t  waddr, raddr_a, raddr_b;
  entry_t wdata, rdata_a, rdata_b;

  slot_t  age_m1;
  len_t   age;
  logic   expire;
  logic   drop;

  swmr_ram #(
    .DEPTH(WINDOW_MAX),
    .WIDTH($bits(entry_t))
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .re_a_i   (re_a),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .re_b_i   (re_b),
    .raddr_b_i(raddr_b),
    .rdata_b_o(rdata_b)
  );

  // age of the front entry seen from the slot about to be written
  assign age_m1 = slot_i - fslot_q - slot_t'(1);
  assign age    = len_t'(age_m1) + len_t'(1);
  assign expire = (cnt_q != '0) && (age >= len_i);

  // tail entry loses against the new sample
  assign drop = (cnt_q != '0) && (max_mode_i ? (tval_q <= x_q) : (tval_q >= x_q));

  // read addresses: next front after a front pop, entry below the tail
  assign raddr_a = head_q + slot_t'(1);
  assign raddr_b = head_q + cnt_q[SLOT_BITS-1:0] - slot_t'(2);
  assign waddr   = head_q + cnt_q[SLOT_BITS-1:0];
  assign wdata   = '{slot: s_q, val: x_q};

  // queue sequencer: front expiry, tail pops, push
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    done_d  = 1'b0;
    fslot_d = fslot_q;
    fval_d  = fval_q;
    tval_d  = tval_q;
    x_d     = x_q;
    s_d     = s_q;
    we      = 1'b0;
    re_a    = 1'b0;
    re_b    = 1'b0;
    case (state_q)
      Q_IDLE: begin
        if (clear_i) begin
          head_d = '0;
          cnt_d  = '0;
        end else if (start_i) begin
          x_d = sample_i;
          s_d = slot_i;
          if (expire) begin
            head_d = head_q + slot_t'(1);
            cnt_d  = cnt_q - len_t'(1);
            re_a   = 1'b1;
          end
          pend_d  = expire && (cnt_q > len_t'(1));
          state_d = Q_BACK;
        end
      end
      Q_BACK: begin
        // new front arrives from the read issued at start
        if (pend_q) begin
          fslot_d = rdata_a.slot;
          fval_d  = rdata_a.val;
        end
        pend_d = 1'b0;
        if (drop) begin
          cnt_d = cnt_q - len_t'(1);
          if (cnt_q > len_t'(1)) begin
            re_b    = 1'b1;
            state_d = Q_TAIL;
          end
        end else begin
          // pops and pushes never share a cycle, so reads see settled data
          we     = 1'b1;
          cnt_d  = cnt_q + len_t'(1);
          tval_d = x_q;
          if (cnt_q == '0) begin
            fslot_d = s_q;
            fval_d  = x_q;
          end
          done_d  = 1'b1;
          state_d = Q_IDLE;
        end
      end
      Q_TAIL: begin
        tval_d  = rdata_b.val;
        state_d = Q_BACK;
      end
      default: begin
        state_d = Q_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Q_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // cached entries and current sample
  always_ff @(posedge clk_i) begin
    fslot_q <= fslot_d;
    fval_q  <= fval_d;
    tval_q  <= tval_d;
    x_q     <= x_d;
    s_q     <= s_d;
  end

  assign stat_o = '{done: done_q, front: fval_q};

endmodule

@@ sv/sliding_window_max_range_unit.sv @@
// top level of the sliding window max range unit
//
// Samples of a set enter on the input channel (in_valid_i / in_stall_o), the
// final sample carrying last_i. Each input transfer yields one result transfer
// on the output channel (out_valid_o / out_stall_i): the best window range
// seen so far in the set, a flag once a full window exists, and the set end
// marker. The window length is written through cfg_we_i / cfg_wdata_i and is
// taken at the first sample of each set.
// Two candidate queues (window minimum and maximum) live in their own rams
// and run side by side. A result reaches the output register once both
// queues have finished the item; each tail pop of a queue adds to that time,
// and a pop that empties the queue needs no tail read. The block takes the
// next item in the cycle after the result has left for the output register
// and stalls its input until then; pops amortize to at most one per sample
// and queue.
// Reset empties both queues, clears the set state and sets the window length
// to 1. A stalled result holds in the output register; the next item still
// enters and waits for the register before it leaves.
module sliding_window_max_range_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  swmr_pkg::cfg_t    cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  swmr_pkg::sample_t sample_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output swmr_pkg::sample_t best_range_o,
  output logic              window_full_o,
  output logic              set_done_o
);
  import swmr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic    state_q, state_d;
  cfg_t    wlen_q;
  len_t    len_q, len_d;
  len_t    pos_q, pos_d;
  slot_t   wslot_q, wslot_d;
  sample_t best_q, best_d;
  logic    full_q, full_d;
  logic    last_q, last_d;
  logic    seen_min_q, seen_min_d;
  logic    seen_max_q, seen_max_d;
  logic    out_valid_q, out_valid_d;
  sample_t out_best_q, out_best_d;
  logic    out_full_q, out_full_d;
  logic    out_last_q, out_last_d;

  qstat_t  min_stat, max_stat;
  logic    accept;
  logic    both_done;
  logic    out_free;
  logic    finish;
  logic    clear;
  len_t    len_eff;
  len_t    pos_next;
  sample_t rng;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign len_eff   = (pos_q == '0) ? clamp_len(wlen_q) : len_q;
  assign pos_next  = (pos_q == len_t'(WINDOW_MAX)) ? pos_q : pos_q + len_t'(1);
  assign both_done = (seen_min_q || min_stat.done) && (seen_max_q || max_stat.done);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign finish    = (state_q == ST_RUN) && both_done && out_free;
  assign clear     = finish && last_q;
  assign rng       = (max_stat.front >= min_stat.front) ?
                     (max_stat.front - min_stat.front) : '0;

  swmr_queue u_min_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .max_mode_i(1'b0),
    .start_i   (accept),
    .clear_i   (clear),
    .sample_i  (sample_i),
    .slot_i    (wslot_q),
    .len_i     (len_eff),
    .stat_o    (min_stat)
  );

  swmr_queue u_max_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .max_mode_i(1'b1),
    .start_i   (accept),
    .clear_i   (clear),
    .sample_i  (sample_i),
    .slot_i    (wslot_q),
    .len_i     (len_eff),
    .stat_o    (max_stat)
  );

  // item control and set state
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pos_d       = pos_q;
    wslot_d     = wslot_q;
    best_d      = best_q;
    full_d      = full_q;
    last_d      = last_q;
    seen_min_d  = seen_min_q;
    seen_max_d  = seen_max_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_best_d  = out_best_q;
    out_full_d  = out_full_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          len_d      = len_eff;
          pos_d      = pos_next;
          wslot_d    = wslot_q + slot_t'(1);
          full_d     = (pos_next >= len_eff);
          last_d     = last_i;
          seen_min_d = 1'b0;
          seen_max_d = 1'b0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        seen_min_d = seen_min_q || min_stat.done;
        seen_max_d = seen_max_q || max_stat.done;
        if (finish) begin
          out_valid_d = 1'b1;
          out_full_d  = full_q;
          out_last_d  = last_q;
          if (full_q && (rng > best_q)) begin
            out_best_d = rng;
            best_d     = rng;
          end else begin
            out_best_d = best_q;
          end
          // set end clears the per-set state
          if (last_q) begin
            pos_d   = '0;
            best_d  = '0;
            wslot_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wlen_q      <= cfg_t'(1);
      len_q       <= len_t'(1);
      pos_q       <= '0;
      wslot_q     <= '0;
      best_q      <= '0;
      seen_min_q  <= 1'b0;
      seen_max_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
      end
      len_q       <= len_d;
      pos_q       <= pos_d;
      wslot_q     <= wslot_d;
      best_q      <= best_d;
      seen_min_q  <= seen_min_d;
      seen_max_q  <= seen_max_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item payload and output register
  always_ff @(posedge clk_i) begin
    full_q     <= full_d;
    last_q     <= last_d;
    out_best_q <= out_best_d;
    out_full_q <= out_full_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign best_range_o  = out_best_q;
  assign window_full_o = out_full_q;
  assign set_done_o    = out_last_q;

endmodule

@@ sv/swmr_checker.sv @@
// port level checks of the sliding window max range unit, bound to the top
module swmr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input swmr_pkg::sample_t sample_i,
  input logic              last_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input swmr_pkg::sample_t best_range_o,
  input logic              window_full_o,
  input logic              set_done_o
);
  import swmr_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(best_range_o) && $stable(window_full_o) && $stable(set_done_o))
    else $error("stalled result changed");

  // a stalled input transfer holds its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(sample_i) && $stable(last_i))
    else $error("stalled input changed");

  // a nonzero range needs a full window
  a_range_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (best_range_o != '0) |-> window_full_o)
    else $error("range reported without a full window");

  // the block is busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a transfer");

  // a new result only comes from an item in progress
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in progress");

endmodule

bind sliding_window_max_range_unit swmr_checker u_swmr_checker (.*);
